[sv/mtd_pkg.sv]
// Package: transaction types, character constants and the Morse code table.
`default_nettype none
package mtd_pkg;

  localparam int unsigned MaxSymbolsDefault = 7;
  localparam int unsigned TableMaxLen       = 7;

  localparam logic [7:0] CharDot     = 8'h2E;
  localparam logic [7:0] CharDash    = 8'h2D;
  localparam logic [7:0] CharUnknown = 8'h5F;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       was_decoded;
  } out_item_t;

  // Key is {length, pattern}; pattern holds the symbols in its low bits,
  // first symbol most significant, dash = 1.
  function automatic logic [7:0] morse_lookup(input logic [2:0] len,
                                              input logic [6:0] pat);
    logic [7:0] ch;
    ch = CharUnknown;
    case ({len, pat})
      {3'd2, 7'd1}:  ch = "A";
      {3'd4, 7'd8}:  ch = "B";
      {3'd4, 7'd10}: ch = "C";
      {3'd3, 7'd4}:  ch = "D";
      {3'd1, 7'd0}:  ch = "E";
      {3'd4, 7'd2}:  ch = "F";
      {3'd3, 7'd6}:  ch = "G";
      {3'd4, 7'd0}:  ch = "H";
      {3'd2, 7'd0}:  ch = "I";
      {3'd4, 7'd7}:  ch = "J";
      {3'd3, 7'd5}:  ch = "K";
      {3'd4, 7'd4}:  ch = "L";
      {3'd2, 7'd3}:  ch = "M";
      {3'd2, 7'd2}:  ch = "N";
      {3'd3, 7'd7}:  ch = "O";
      {3'd4, 7'd6}:  ch = "P";
      {3'd4, 7'd13}: ch = "Q";
      {3'd3, 7'd2}:  ch = "R";
      {3'd3, 7'd0}:  ch = "S";
      {3'd1, 7'd1}:  ch = "T";
      {3'd3, 7'd1}:  ch = "U";
      {3'd4, 7'd1}:  ch = "V";
      {3'd3, 7'd3}:  ch = "W";
      {3'd4, 7'd9}:  ch = "X";
      {3'd4, 7'd11}: ch = "Y";
      {3'd4, 7'd12}: ch = "Z";
      {3'd5, 7'd31}: ch = "0";
      {3'd5, 7'd15}: ch = "1";
      {3'd5, 7'd7}:  ch = "2";
      {3'd5, 7'd3}:  ch = "3";
      {3'd5, 7'd1}:  ch = "4";
      {3'd5, 7'd0}:  ch = "5";
      {3'd5, 7'd16}: ch = "6";
      {3'd5, 7'd24}: ch = "7";
      {3'd5, 7'd28}: ch = "8";
      {3'd5, 7'd30}: ch = "9";
      {3'd6, 7'd21}: ch = ".";
      {3'd6, 7'd51}: ch = ",";
      {3'd6, 7'd12}: ch = "?";
      {3'd6, 7'd30}: ch = 8'h27;
      {3'd6, 7'd43}: ch = "!";
      {3'd5, 7'd18}: ch = "/";
      {3'd5, 7'd22}: ch = "(";
      {3'd6, 7'd45}: ch = ")";
      {3'd5, 7'd8}:  ch = "&";
      {3'd6, 7'd56}: ch = ":";
      {3'd6, 7'd42}: ch = ";";
      {3'd5, 7'd17}: ch = "=";
      {3'd5, 7'd10}: ch = "+";
      {3'd6, 7'd33}: ch = "-";
      {3'd6, 7'd13}: ch = "_";
      {3'd6, 7'd18}: ch = 8'h22;
      {3'd7, 7'd9}:  ch = "$";
      {3'd6, 7'd26}: ch = "@";
      default:       ch = CharUnknown;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

[sv/mtd_lookup.sv]
// Morse code lookup: pending code to character, with overflow and unknown handling.
`default_nettype none
module mtd_lookup
  import mtd_pkg::*;
#(
  parameter int unsigned MaxSymbols = MaxSymbolsDefault,
  localparam int unsigned LenW      = $clog2(MaxSymbols + 1)
) (
  input  wire logic [MaxSymbols-1:0] sym_i,
  input  wire logic [LenW-1:0]       len_i,
  input  wire logic                  ovf_i,
  output logic      [7:0]            char_o
);

  logic fits;

  assign fits = (len_i <= LenW'(TableMaxLen));

  always_comb begin
    if (ovf_i || !fits) begin
      char_o = CharUnknown;
    end else begin
      char_o = morse_lookup(len_i[2:0], sym_i[TableMaxLen-1:0]);
    end
  end

endmodule
`default_nettype wire

[sv/mtd_code.sv]
// Code accumulator: pending symbol state, per-character step and result selection.
`default_nettype none
module mtd_code
  import mtd_pkg::*;
#(
  parameter int unsigned MaxSymbols = MaxSymbolsDefault,
  localparam int unsigned LenW      = $clog2(MaxSymbols + 1)
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire in_item_t  item_i,
  output logic           res_valid_o,
  output out_item_t      res_item_o
);

  logic [MaxSymbols-1:0] sym_q, sym_d, sym_nx, look_sym;
  logic [LenW-1:0]       len_q, len_d, len_nx, look_len;
  logic                  ovf_q, ovf_d, ovf_nx, look_ovf;
  logic                  in_code_q, in_code_d;
  logic                  is_sym, is_dash, room;
  logic [7:0]            dec_char;

  assign is_dash = (item_i.char_in == CharDash);
  assign is_sym  = is_dash || (item_i.char_in == CharDot);
  assign room    = (len_q < LenW'(MaxSymbols));

  assign sym_nx = room ? {sym_q[MaxSymbols-2:0], is_dash} : sym_q;
  assign len_nx = room ? len_q + LenW'(1) : len_q;
  assign ovf_nx = ovf_q | ~room;

  assign look_sym = is_sym ? sym_nx : sym_q;
  assign look_len = is_sym ? len_nx : len_q;
  assign look_ovf = is_sym ? ovf_nx : ovf_q;

  mtd_lookup #(
    .MaxSymbols(MaxSymbols)
  ) u_lookup (
    .sym_i (look_sym),
    .len_i (look_len),
    .ovf_i (look_ovf),
    .char_o(dec_char)
  );

  always_comb begin
    if (is_sym) begin
      res_valid_o            = item_i.end_of_text;
      res_item_o.char_out    = dec_char;
      res_item_o.was_decoded = 1'b1;
    end else if (in_code_q) begin
      res_valid_o            = 1'b1;
      res_item_o.char_out    = dec_char;
      res_item_o.was_decoded = 1'b1;
    end else begin
      res_valid_o            = 1'b1;
      res_item_o.char_out    = item_i.char_in;
      res_item_o.was_decoded = 1'b0;
    end
  end

  always_comb begin
    sym_d     = sym_q;
    len_d     = len_q;
    ovf_d     = ovf_q;
    in_code_d = in_code_q;
    if (step_i) begin
      if (item_i.end_of_text || (!is_sym && in_code_q)) begin
        sym_d     = '0;
        len_d     = '0;
        ovf_d     = 1'b0;
        in_code_d = 1'b0;
      end else if (is_sym) begin
        sym_d     = sym_nx;
        len_d     = len_nx;
        ovf_d     = ovf_nx;
        in_code_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q     <= '0;
      len_q     <= '0;
      ovf_q     <= 1'b0;
      in_code_q <= 1'b0;
    end else begin
      sym_q     <= sym_d;
      len_q     <= len_d;
      ovf_q     <= ovf_d;
      in_code_q <= in_code_d;
    end
  end

endmodule
`default_nettype wire

[sv/morse_text_decoder_unit.sv]
// Top level: Morse text decoder with input register and result register.
//
// Takes one text character per transaction and returns decoded Morse letters,
// digits and signs, passing other characters through. Dots and dashes gather
// into a pending code and give no result; the next other character ends the
// code, yields its decoded character and is itself dropped. end_of_text
// flushes a pending code. Unknown or overlong codes decode to underscore.
// One transaction is taken every cycle while the result is not stalled. A result
// passes through the input register, then the result register, before it is
// presented on the output. The pending-code state in mtd_code is updated as
// each transaction advances, which allows this rate. A stalled result holds the
// input register, and the input stalls only while both registers are full.
`default_nettype none
module morse_text_decoder_unit
  import mtd_pkg::*;
#(
  parameter int unsigned MaxSymbols = MaxSymbolsDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  logic      in_vld_q, in_vld_d;
  in_item_t  in_item_q;
  logic      out_vld_q, out_vld_d;
  out_item_t out_item_q;
  logic      adv, accept, out_free, res_valid;
  out_item_t res_item;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  mtd_code #(
    .MaxSymbols(MaxSymbols)
  ) u_code (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (adv),
    .item_i     (in_item_q),
    .res_valid_o(res_valid),
    .res_item_o (res_item)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv && res_valid) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
    if (adv && res_valid) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

[sv/mtd_checker.sv]
// Checker: port-level properties of the Morse text decoder, bound to the top level.
`default_nettype none
module mtd_checker
  import mtd_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire in_item_t  in_item_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_item_o
);

  logic unused_in;
  assign unused_in = in_valid_i ^ in_stall_o ^ (^in_item_i);

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  a_no_symbol_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.was_decoded |->
      (out_item_o.char_out != CharDot) && (out_item_o.char_out != CharDash))
    else $error("Morse symbol passed through");

  a_decoded_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.was_decoded |-> (out_item_o.char_out <= CharUnknown))
    else $error("decoded character outside the table");

endmodule

bind morse_text_decoder_unit mtd_checker u_mtd_checker (.*);
`default_nettype wire
